/* src/dps_pkg.sv */
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants of the dynamic priority scheduler.
// ----------------------------------------------------------------------------
package dps_pkg;

	localparam int DEF_SLOTS = 8;

	localparam int ID_W    = 8;
	localparam int TIME_W  = 16;
	localparam int PRIO_W  = 8;
	localparam int SPRIO_W = 7;
	localparam int STAT_W  = 3;
	localparam int ENTRY_W = ID_W + TIME_W + PRIO_W;

	// input kinds carried on tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result codes carried on tuser
	localparam logic [STAT_W-1:0] STAT_LOADED   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_RAN      = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FINISHED = 3'd3;
	localparam logic [STAT_W-1:0] STAT_IDLE     = 3'd4;

	localparam logic signed [PRIO_W-1:0] PRIO_FLOOR = -8'sd128;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} dps_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} dps_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} dps_sts_t;

endpackage

/* src/dps_ram.sv */
// ----------------------------------------------------------------------------
// dps_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dps_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/dps_ctrl.sv */
// ----------------------------------------------------------------------------
// dps_ctrl
// Sequencer: accepts a beat, sweeps the slot table, then commits the result.
// ----------------------------------------------------------------------------
module dps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  dps_pkg::dps_sts_t sts,
	output dps_pkg::dps_cmd_t cmd
);
	import dps_pkg::*;

	dps_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		cmd           = '0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.start     = s_axis_tvalid;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_DRAIN: begin
			end
			S_COMMIT: begin
				cmd.commit = !sts.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/dps_dpath.sv */
// ----------------------------------------------------------------------------
// dps_dpath
// Slot table, scan comparator, write-back and output register.
// ----------------------------------------------------------------------------
module dps_dpath #(
	parameter int SLOTS = dps_pkg::DEF_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dps_pkg::dps_cmd_t           cmd,
	output dps_pkg::dps_sts_t           sts,
	input  logic                        in_op,
	input  logic [dps_pkg::ID_W-1:0]    in_task_id,
	input  logic [dps_pkg::TIME_W-1:0]  in_run_time,
	input  logic [dps_pkg::SPRIO_W-1:0] in_start_priority,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dps_pkg::STAT_W-1:0]  out_status,
	output logic [dps_pkg::ID_W-1:0]    out_ran_id,
	output logic [dps_pkg::TIME_W-1:0]  out_time_left,
	output logic [dps_pkg::PRIO_W-1:0]  out_prio_now
);
	import dps_pkg::*;

	localparam int IW = $clog2(SLOTS);

	// captured request
	logic                op_q;
	logic [ID_W-1:0]     id_q;
	logic [TIME_W-1:0]   time_q;
	logic [SPRIO_W-1:0]  prio_q;

	logic [SLOTS-1:0]    valid_q;
	logic [IW-1:0]       cnt_q;
	logic                rd_vld_s1;
	logic [IW-1:0]       idx_s1;
	logic                slot_v_s1;

	logic                found_q;
	logic [IW-1:0]       best_idx_q;
	logic [ID_W-1:0]     best_id_q;
	logic [TIME_W-1:0]   best_time_q;
	logic signed [PRIO_W-1:0] best_prio_q;

	logic [ENTRY_W-1:0]  rdata;
	logic [ID_W-1:0]     rd_id;
	logic [TIME_W-1:0]   rd_time;
	logic signed [PRIO_W-1:0] rd_prio;
	logic                take;

	logic                ram_we;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [TIME_W-1:0]   new_time;
	logic signed [PRIO_W-1:0] new_prio;
	logic                load_ok;

	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [ID_W-1:0]     ran_id_q;
	logic [TIME_W-1:0]   time_left_q;
	logic [PRIO_W-1:0]   prio_now_q;

	assign rd_id   = rdata[ID_W-1:0];
	assign rd_time = rdata[ID_W+TIME_W-1:ID_W];
	assign rd_prio = $signed(rdata[ENTRY_W-1:ID_W+TIME_W]);

	assign sts.scan_last = (cnt_q == IW'(SLOTS - 1));
	assign sts.out_busy  = out_valid_q && !out_ready;

	// a load wants the first free slot, a tick the best valid one
	always_comb begin
		take = 1'b0;
		if (rd_vld_s1) begin
			if (op_q == OP_LOAD) begin
				take = !slot_v_s1 && !found_q;
			end else begin
				take = slot_v_s1 && (!found_q || (rd_prio > best_prio_q));
			end
		end
	end

	assign new_prio = (best_prio_q == PRIO_FLOOR) ? best_prio_q : best_prio_q - 8'sd1;
	assign new_time = (best_time_q != '0) ? best_time_q - TIME_W'(1) : best_time_q;
	assign load_ok  = found_q && (time_q != '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {new_prio, new_time, best_id_q};
		if (cmd.commit) begin
			if (op_q == OP_LOAD) begin
				ram_we    = load_ok;
				ram_wdata = {1'b0, prio_q, time_q, id_q};
			end else begin
				ram_we = found_q;
			end
		end
	end

	dps_ram #(
		.W     (ENTRY_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (best_idx_q),
		.wdata (ram_wdata),
		.raddr (cnt_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= in_op;
			id_q   <= in_task_id;
			time_q <= in_run_time;
			prio_q <= in_start_priority;
		end
		idx_s1    <= cnt_q;
		slot_v_s1 <= valid_q[cnt_q];
		if (take) begin
			best_idx_q  <= idx_s1;
			best_id_q   <= rd_id;
			best_time_q <= rd_time;
			best_prio_q <= rd_prio;
		end
		if (cmd.commit) begin
			if (op_q == OP_LOAD) begin
				status_q    <= load_ok ? STAT_LOADED : STAT_DROPPED;
				ran_id_q    <= '0;
				time_left_q <= '0;
				prio_now_q  <= '0;
			end else if (!found_q) begin
				status_q    <= STAT_IDLE;
				ran_id_q    <= '0;
				time_left_q <= '0;
				prio_now_q  <= '0;
			end else begin
				status_q    <= (new_time == '0) ? STAT_FINISHED : STAT_RAN;
				ran_id_q    <= best_id_q;
				time_left_q <= new_time;
				prio_now_q  <= new_prio;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cmd.scan) begin
				cnt_q <= sts.scan_last ? '0 : cnt_q + IW'(1);
			end
			if (cmd.start) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (op_q == OP_LOAD) begin
					if (load_ok) begin
						valid_q[best_idx_q] <= 1'b1;
					end
				end else if (found_q && new_time == '0) begin
					valid_q[best_idx_q] <= 1'b0;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_status    = status_q;
	assign out_ran_id    = ran_id_q;
	assign out_time_left = time_left_q;
	assign out_prio_now  = prio_now_q;

	// no read may still be in flight when the result is written back
	a_commit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !rd_vld_s1 && !cmd.scan)
		else $error("commit while slot scan still in flight");

	// a held result must never be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !out_ready))
		else $error("result register overwritten while stalled");

	// an accepted load leaves its slot marked in use
	a_load_marks_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_LOAD && load_ok) |=> valid_q[$past(best_idx_q)])
		else $error("loaded slot not marked valid");

	// the sweep counter rests at zero outside a scan
	a_cnt_rest: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> cnt_q == '0)
		else $error("scan counter not at zero on new beat");

endmodule

/* src/dynamic_priority_scheduler_top.sv */
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler_top
// Task table scheduled by dynamic priority, highest first, lowest slot on tie.
// ----------------------------------------------------------------------------
// input stream: s_axis_tuser is the kind (load or tick), s_axis_tdata the task.
// a load puts the task in the lowest free slot, or drops it when the table is
// full or its run time is zero. a tick runs the best valid task, lowers its
// priority (floor -128) and its time, and frees the slot when the time runs out.
// output stream: one result beat per input beat, m_axis_tuser holds the status.
// each beat sweeps every slot once through the table ram, one slot a cycle,
// then writes back its result; a new input beat is taken only after the
// previous beat has been written back.
// the result sits in an output register, so a new beat is taken and scanned
// while the previous result still waits; a stalled receiver holds the block
// only at write-back, until the held result is taken.
// reset empties the table (all slot valid bits cleared) and drops any result
// not yet taken; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler_top #(
	parameter int SLOTS = dps_pkg::DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // task_id[7:0], run_time[23:8], start_priority[30:24]
	input  logic        s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // ran_id[7:0], time_left[23:8], prio_now[31:24]
	output logic [2:0]  m_axis_tuser    // status
);
	import dps_pkg::*;

	dps_cmd_t cmd;
	dps_sts_t sts;

	dps_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	dps_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_op             (s_axis_tuser),
		.in_task_id        (s_axis_tdata[7:0]),
		.in_run_time       (s_axis_tdata[23:8]),
		.in_start_priority (s_axis_tdata[30:24]),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_status        (m_axis_tuser),
		.out_ran_id        (m_axis_tdata[7:0]),
		.out_time_left     (m_axis_tdata[23:8]),
		.out_prio_now      (m_axis_tdata[31:24])
	);

endmodule

/* dv/tb_dynamic_priority_scheduler_top.sv */
// ----------------------------------------------------------------------------
// tb_dynamic_priority_scheduler_top
// Self-checking bench for the dynamic priority scheduler.
// ----------------------------------------------------------------------------
// load and tick beats go in on the slave stream, and every accepted beat is
// run through a task table kept in the bench. That table gives the result
// the block owes for the beat. Result beats are compared in order, field by
// field. Both sides insert random idle cycles. The random stimulus mixes loads
// and ticks, fills the table, and runs long tasks down to the priority floor.
// ----------------------------------------------------------------------------
module tb_dynamic_priority_scheduler_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dps_pkg::*;

	localparam int SLOTS      = DEF_SLOTS;
	localparam int LATENCY    = SLOTS + 3;
	localparam int RAND_ITEMS = 1700;
	localparam int CYCLE_CAP  = 500000;

	typedef struct {
		logic [STAT_W-1:0]        status;
		logic [ID_W-1:0]          id;
		logic [TIME_W-1:0]        left;
		logic signed [PRIO_W-1:0] prio;
	} outcome_t;

	// task table kept alongside the block, plus the results it still owes
	class task_table_check;
		logic                     busy [SLOTS];
		logic [ID_W-1:0]          tid  [SLOTS];
		logic [TIME_W-1:0]        left [SLOTS];
		logic signed [PRIO_W-1:0] prio [SLOTS];
		outcome_t                 outcome_q [$];
		int errors, compared, loads, drops, runs, finishes, idles, floor_hits;

		function void clear_table();
			foreach (busy[i]) busy[i] = 1'b0;
		endfunction

		function int occupied();
			int n;
			n = 0;
			foreach (busy[i]) if (busy[i]) n++;
			return n;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		function void take_item(logic op, logic [ID_W-1:0] id_in, logic [TIME_W-1:0] run,
				logic [SPRIO_W-1:0] sprio);
			outcome_t o;
			int slot;
			logic signed [PRIO_W-1:0] best_prio;
			o.status = STAT_LOADED;
			o.id     = '0;
			o.left   = '0;
			o.prio   = '0;
			slot     = -1;
			best_prio = '0;
			if (op == OP_LOAD) begin
				foreach (busy[i]) if (!busy[i] && slot < 0) slot = i;
				if (run == '0 || slot < 0) begin
					o.status = STAT_DROPPED;
					drops++;
				end else begin
					busy[slot] = 1'b1;
					tid[slot]  = id_in;
					left[slot] = run;
					prio[slot] = {1'b0, sprio};
					loads++;
				end
			end else begin
				// strict compare keeps the lowest slot on a tie
				foreach (busy[i]) begin
					if (busy[i] && (slot < 0 || prio[i] > best_prio)) begin
						slot      = i;
						best_prio = prio[i];
					end
				end
				if (slot < 0) begin
					o.status = STAT_IDLE;
					idles++;
				end else begin
					if (prio[slot] != PRIO_FLOOR) prio[slot] = prio[slot] - 8'sd1;
					else floor_hits++;
					if (left[slot] != '0) left[slot] = left[slot] - 16'd1;
					o.id   = tid[slot];
					o.left = left[slot];
					o.prio = prio[slot];
					runs++;
					if (left[slot] == '0) begin
						busy[slot] = 1'b0;
						o.status   = STAT_FINISHED;
						finishes++;
					end else begin
						o.status = STAT_RAN;
					end
				end
			end
			outcome_q = {outcome_q, o};
		endfunction

		function void report(string what);
			errors++;
			// keep the log short on a badly broken build
			if (errors <= 40) $display("mismatch at %0t: %s", $time, what);
		endfunction

		function void match_result(logic [STAT_W-1:0] st, logic [31:0] data);
			outcome_t o;
			if (outcome_q.size() == 0) begin
				report($sformatf("result beat with none owed, status %0d data %h", st, data));
				return;
			end
			o = outcome_q.pop_front();
			compared++;
			if (st !== o.status)
				report($sformatf("beat %0d status %0d, wanted %0d", compared, st, o.status));
			if (data[7:0] !== o.id)
				report($sformatf("beat %0d ran_id %h, wanted %h", compared, data[7:0], o.id));
			if (data[23:8] !== o.left)
				report($sformatf("beat %0d time_left %h, wanted %h", compared, data[23:8],
					o.left));
			if (data[31:24] !== o.prio)
				report($sformatf("beat %0d prio_now %0d, wanted %0d", compared,
					$signed(data[31:24]), o.prio));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = OP_LOAD;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	task_table_check sched = new();
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int sent;

	dynamic_priority_scheduler_top #(
		.SLOTS(SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	task automatic send_item(input logic op, input logic [ID_W-1:0] id_in,
			input logic [TIME_W-1:0] run, input logic [SPRIO_W-1:0] sprio);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, sprio, run, id_in};
		do @(posedge clk); while (!s_axis_tready);
		sched.take_item(op, id_in, run, sprio);
		sent++;
	endtask

	// ignored fields of a tick still carry random bits
	task automatic send_tick();
		send_item(OP_TICK, ID_W'($urandom), TIME_W'($urandom), SPRIO_W'($urandom));
	endtask

	task automatic send_load(input logic [TIME_W-1:0] run);
		logic [SPRIO_W-1:0] sp;
		sp = ($urandom_range(0, 3) == 0) ? 7'd64 : SPRIO_W'($urandom_range(0, 127));
		if (sched.occupied() == SLOTS) run = TIME_W'($urandom);
		send_item(OP_LOAD, ID_W'($urandom), run, sp);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sched.pending() != 0) @(posedge clk);
	endtask

	// result side
	initial begin
		int unsigned gap;
		int beats;
		wait (arst_n === 1'b1);
		beats = 0;
		forever begin
			if (beats % 64 == 63) rx_idle = ($urandom_range(0, 3) != 0);
			gap = rx_idle ? $urandom_range(0, 13) : 0;
			@(negedge clk);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sched.match_result(m_axis_tuser, m_axis_tdata);
			beats++;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		repeat (CYCLE_CAP) @(posedge clk);
		$display("timeout after %0d cycles, %0d results still owed", CYCLE_CAP,
			sched.pending());
		$display("FAIL dynamic_priority_scheduler_top");
		$finish;
	end

	initial begin
		int next_floor;
		int n;
		sched.clear_table();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: idle, zero time, finish, ties, full table
		send_item(OP_TICK, 8'hFF, 16'hFFFF, 7'h7F);
		send_item(OP_LOAD, 8'h00, 16'h0000, 7'h7F);
		send_item(OP_LOAD, 8'h00, 16'h0001, 7'h00);
		send_item(OP_LOAD, 8'hFF, 16'h0002, 7'h7F);
		repeat (3) send_tick();
		send_item(OP_TICK, 8'h00, 16'h0000, 7'h00);
		send_item(OP_LOAD, 8'h55, 16'h0003, 7'h40);
		send_item(OP_LOAD, 8'hAA, 16'h0003, 7'h40);
		repeat (3) send_tick();
		for (int i = 0; i < 6; i++)
			send_item(OP_LOAD, ID_W'(8'h10 + i), TIME_W'(16'h0001 + i),
				SPRIO_W'(7'h40 - i));
		send_item(OP_LOAD, 8'hFF, 16'hFFFF, 7'h7F);
		send_item(OP_LOAD, 8'h81, 16'h8000, 7'h01);
		wait_drained();

		next_floor = sent + $urandom_range(100, 600);
		while (sent < RAND_ITEMS) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			if (sent >= next_floor) begin
				// long tasks from low priority end up pinned at the floor
				while (sched.occupied() != 0) send_tick();
				wait_drained();
				repeat (2) send_item(OP_LOAD, ID_W'($urandom),
					TIME_W'($urandom_range(140, 160)), SPRIO_W'($urandom_range(0, 2)));
				while (sched.occupied() != 0) send_tick();
				next_floor = sent + 700;
			end else if ($urandom_range(0, 9) < 2) begin
				while (sched.occupied() < SLOTS) send_load(TIME_W'($urandom_range(1, 12)));
				n = $urandom_range(1, 3);
				repeat (n) send_load(16'h0000);
			end else begin
				repeat (20) begin
					if ($urandom_range(0, 1) == 0) send_tick();
					else if ($urandom_range(0, 15) == 0) send_load(16'h0000);
					else send_load(TIME_W'($urandom_range(1, 12)));
				end
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (3 * LATENCY) @(posedge clk);

		$display("%0d beats in, %0d results checked: %0d loads, %0d dropped, %0d idle ticks",
			sent, sched.compared, sched.loads, sched.drops, sched.idles);
		$display("%0d runs, %0d finished, %0d at the priority floor, %0d mismatches",
			sched.runs, sched.finishes, sched.floor_hits, sched.errors);
		if (sched.errors == 0 && sched.pending() == 0)
			$display("PASS dynamic_priority_scheduler_top");
		else
			$display("FAIL dynamic_priority_scheduler_top");
		$finish;
	end

endmodule

/* sim.f */
src/dps_pkg.sv
src/dps_ram.sv
src/dps_ctrl.sv
src/dps_dpath.sv
src/dynamic_priority_scheduler_top.sv
dv/tb_dynamic_priority_scheduler_top.sv
